>>> hdl/stfp_pkg.sv
// Shared types, constants and the CRC-8 step function for the snapshot frame packer.
// Used by stfp_ucode_rom, stfp_datapath and snapshot_two_frame_packer_crc8_unit.
// No dependencies.
`default_nettype none

package stfp_pkg;

	// Snapshot geometry
	localparam int unsigned SNAP_LEN = 66;
	localparam int unsigned HEAD_LEN = 10;
	localparam int unsigned POS_W    = 7;
	localparam int unsigned HEAD_W   = 4;

	// Positions that start or end a frame
	localparam logic [POS_W-1:0] POS_FRAME0 = 7'd9;
	localparam logic [POS_W-1:0] POS_END0   = 7'd32;
	localparam logic [POS_W-1:0] POS_FRAME1 = 7'd33;
	localparam logic [POS_W-1:0] POS_LAST   = 7'd65;

	// Frame header bytes
	localparam logic [7:0] HDR_SYNC = 8'hee;
	localparam logic [7:0] HDR_LEN  = 8'd47;
	localparam logic [7:0] HDR_TYPE = 8'hea;
	localparam logic [7:0] HDR_DEST = 8'hee;
	localparam logic [7:0] HDR_ORIG = 8'hc8;
	localparam logic [7:0] HDR_VER  = 8'd1;

	// CRC-8, MSB first, init 0, no final xor
	localparam logic [7:0] CRC_POLY = 8'hd5;

	// Microcode layout
	localparam int unsigned       UC_ADDR_W   = 5;
	localparam logic [UC_ADDR_W-1:0] UC_HEAD  = 5'd0;
	localparam logic [UC_ADDR_W-1:0] UC_PASS  = 5'd25;
	localparam logic [UC_ADDR_W-1:0] UC_CRC   = 5'd26;
	localparam logic [UC_ADDR_W-1:0] UC_LEN   = 5'd27;

	// Data source of one output byte
	typedef enum logic [2:0] {
		SRC_CONST = 3'd0,
		SRC_HEAD  = 3'd1,
		SRC_BYTE  = 3'd2,
		SRC_PART  = 3'd3,
		SRC_CRC   = 3'd4
	} src_t;

	// Sequencing action after a step
	typedef enum logic [1:0] {
		SEQ_NEXT            = 2'd0,
		SEQ_LAST            = 2'd1,
		SEQ_JUMP_IF_PART1   = 2'd2,
		SEQ_LAST_UNLESS_END = 2'd3
	} seq_t;

	// One microcode control word
	typedef struct packed {
		src_t                 src;
		logic [7:0]           konst;
		logic [HEAD_W-1:0]    head_idx;
		logic                 crc_clr;
		logic                 crc_upd;
		logic                 frame_end;
		seq_t                 seq;
		logic [UC_ADDR_W-1:0] target;
	} ctrl_word_t;

	// Step command from sequencer to datapath
	typedef struct packed {
		logic       fire;
		logic       last;
		ctrl_word_t cw;
	} dp_ctrl_t;

	// Fold one byte into the running CRC
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] x;
		x = crc ^ data;
		for (int i = 0; i < 8; i++) begin
			x = {x[6:0], 1'b0} ^ (x[7] ? CRC_POLY : 8'h00);
		end
		return x;
	endfunction

endpackage

`default_nettype wire

>>> hdl/stfp_ucode_rom.sv
// Microcode ROM of the snapshot frame packer: one control word per output byte step.
// Depends on stfp_pkg for the control word type and header constants.
`default_nettype none

module stfp_ucode_rom (
	input  wire logic [stfp_pkg::UC_ADDR_W-1:0] addr,
	output stfp_pkg::ctrl_word_t                word
);

	// Build one control word
	function automatic stfp_pkg::ctrl_word_t mk(
		input stfp_pkg::src_t                 src,
		input logic [7:0]                     konst,
		input logic [stfp_pkg::HEAD_W-1:0]    idx,
		input logic                           clr,
		input logic                           upd,
		input logic                           fend,
		input stfp_pkg::seq_t                 seq,
		input logic [stfp_pkg::UC_ADDR_W-1:0] tgt
	);
		stfp_pkg::ctrl_word_t w;
		w.src       = src;
		w.konst     = konst;
		w.head_idx  = idx;
		w.crc_clr   = clr;
		w.crc_upd   = upd;
		w.frame_end = fend;
		w.seq       = seq;
		w.target    = tgt;
		return w;
	endfunction

	// Program: header (shared by both frames), head bytes 0..9 for frame 0,
	// pass-through byte, and the closing CRC byte
	always_comb begin
		unique case (addr)
			5'd0:  word = mk(stfp_pkg::SRC_CONST, stfp_pkg::HDR_SYNC, 4'd0, 1'b1, 1'b0, 1'b0,
				stfp_pkg::SEQ_NEXT, stfp_pkg::UC_HEAD);
			5'd1:  word = mk(stfp_pkg::SRC_CONST, stfp_pkg::HDR_LEN, 4'd0, 1'b0, 1'b0, 1'b0,
				stfp_pkg::SEQ_NEXT, stfp_pkg::UC_HEAD);
			5'd2:  word = mk(stfp_pkg::SRC_CONST, stfp_pkg::HDR_TYPE, 4'd0, 1'b0, 1'b1, 1'b0,
				stfp_pkg::SEQ_NEXT, stfp_pkg::UC_HEAD);
			5'd3:  word = mk(stfp_pkg::SRC_CONST, stfp_pkg::HDR_DEST, 4'd0, 1'b0, 1'b1, 1'b0,
				stfp_pkg::SEQ_NEXT, stfp_pkg::UC_HEAD);
			5'd4:  word = mk(stfp_pkg::SRC_CONST, stfp_pkg::HDR_ORIG, 4'd0, 1'b0, 1'b1, 1'b0,
				stfp_pkg::SEQ_NEXT, stfp_pkg::UC_HEAD);
			5'd5:  word = mk(stfp_pkg::SRC_CONST, stfp_pkg::HDR_VER, 4'd0, 1'b0, 1'b1, 1'b0,
				stfp_pkg::SEQ_NEXT, stfp_pkg::UC_HEAD);
			5'd6:  word = mk(stfp_pkg::SRC_PART, 8'h00, 4'd0, 1'b0, 1'b1, 1'b0,
				stfp_pkg::SEQ_NEXT, stfp_pkg::UC_HEAD);
			5'd7:  word = mk(stfp_pkg::SRC_HEAD, 8'h00, 4'd2, 1'b0, 1'b1, 1'b0,
				stfp_pkg::SEQ_NEXT, stfp_pkg::UC_HEAD);
			5'd8:  word = mk(stfp_pkg::SRC_HEAD, 8'h00, 4'd3, 1'b0, 1'b1, 1'b0,
				stfp_pkg::SEQ_NEXT, stfp_pkg::UC_HEAD);
			5'd9:  word = mk(stfp_pkg::SRC_HEAD, 8'h00, 4'd4, 1'b0, 1'b1, 1'b0,
				stfp_pkg::SEQ_NEXT, stfp_pkg::UC_HEAD);
			5'd10: word = mk(stfp_pkg::SRC_HEAD, 8'h00, 4'd5, 1'b0, 1'b1, 1'b0,
				stfp_pkg::SEQ_NEXT, stfp_pkg::UC_HEAD);
			5'd11: word = mk(stfp_pkg::SRC_HEAD, 8'h00, 4'd6, 1'b0, 1'b1, 1'b0,
				stfp_pkg::SEQ_NEXT, stfp_pkg::UC_HEAD);
			5'd12: word = mk(stfp_pkg::SRC_HEAD, 8'h00, 4'd7, 1'b0, 1'b1, 1'b0,
				stfp_pkg::SEQ_NEXT, stfp_pkg::UC_HEAD);
			5'd13: word = mk(stfp_pkg::SRC_HEAD, 8'h00, 4'd8, 1'b0, 1'b1, 1'b0,
				stfp_pkg::SEQ_NEXT, stfp_pkg::UC_HEAD);
			// Frame 1 leaves the header for the pass-through step
			5'd14: word = mk(stfp_pkg::SRC_HEAD, 8'h00, 4'd9, 1'b0, 1'b1, 1'b0,
				stfp_pkg::SEQ_JUMP_IF_PART1, stfp_pkg::UC_PASS);
			5'd15: word = mk(stfp_pkg::SRC_HEAD, 8'h00, 4'd0, 1'b0, 1'b1, 1'b0,
				stfp_pkg::SEQ_NEXT, stfp_pkg::UC_HEAD);
			5'd16: word = mk(stfp_pkg::SRC_HEAD, 8'h00, 4'd1, 1'b0, 1'b1, 1'b0,
				stfp_pkg::SEQ_NEXT, stfp_pkg::UC_HEAD);
			5'd17: word = mk(stfp_pkg::SRC_HEAD, 8'h00, 4'd2, 1'b0, 1'b1, 1'b0,
				stfp_pkg::SEQ_NEXT, stfp_pkg::UC_HEAD);
			5'd18: word = mk(stfp_pkg::SRC_HEAD, 8'h00, 4'd3, 1'b0, 1'b1, 1'b0,
				stfp_pkg::SEQ_NEXT, stfp_pkg::UC_HEAD);
			5'd19: word = mk(stfp_pkg::SRC_HEAD, 8'h00, 4'd4, 1'b0, 1'b1, 1'b0,
				stfp_pkg::SEQ_NEXT, stfp_pkg::UC_HEAD);
			5'd20: word = mk(stfp_pkg::SRC_HEAD, 8'h00, 4'd5, 1'b0, 1'b1, 1'b0,
				stfp_pkg::SEQ_NEXT, stfp_pkg::UC_HEAD);
			5'd21: word = mk(stfp_pkg::SRC_HEAD, 8'h00, 4'd6, 1'b0, 1'b1, 1'b0,
				stfp_pkg::SEQ_NEXT, stfp_pkg::UC_HEAD);
			5'd22: word = mk(stfp_pkg::SRC_HEAD, 8'h00, 4'd7, 1'b0, 1'b1, 1'b0,
				stfp_pkg::SEQ_NEXT, stfp_pkg::UC_HEAD);
			5'd23: word = mk(stfp_pkg::SRC_HEAD, 8'h00, 4'd8, 1'b0, 1'b1, 1'b0,
				stfp_pkg::SEQ_NEXT, stfp_pkg::UC_HEAD);
			5'd24: word = mk(stfp_pkg::SRC_HEAD, 8'h00, 4'd9, 1'b0, 1'b1, 1'b0,
				stfp_pkg::SEQ_LAST, stfp_pkg::UC_HEAD);
			// Pass the input byte; continue to the CRC byte at frame end
			5'd25: word = mk(stfp_pkg::SRC_BYTE, 8'h00, 4'd0, 1'b0, 1'b1, 1'b0,
				stfp_pkg::SEQ_LAST_UNLESS_END, stfp_pkg::UC_HEAD);
			5'd26: word = mk(stfp_pkg::SRC_CRC, 8'h00, 4'd0, 1'b0, 1'b0, 1'b1,
				stfp_pkg::SEQ_LAST, stfp_pkg::UC_HEAD);
			default: word = mk(stfp_pkg::SRC_CONST, 8'h00, 4'd0, 1'b0, 1'b0, 1'b0,
				stfp_pkg::SEQ_LAST, stfp_pkg::UC_HEAD);
		endcase
	end

endmodule

`default_nettype wire

>>> hdl/stfp_datapath.sv
// Datapath of the snapshot frame packer: head buffer, input byte, CRC and output register.
// Driven one step at a time by the microcode sequencer; depends on stfp_pkg.
`default_nettype none

module stfp_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_take,
	input  wire logic                          head_we,
	input  wire logic [stfp_pkg::HEAD_W-1:0]   head_widx,
	input  wire logic [7:0]                    in_data,
	input  wire logic                          part,
	input  wire stfp_pkg::dp_ctrl_t            ctrl,
	output logic                               slot_free,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [7:0]                         out_byte,
	output logic                               frame_part,
	output logic                               frame_end,
	output logic                               run_last
);

	logic [7:0] head_q [stfp_pkg::HEAD_LEN];
	logic [7:0] byte_q;
	logic [7:0] crc_q;
	logic [7:0] value;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       frame_part_q;
	logic       frame_end_q;
	logic       run_last_q;

	// Capture the head bytes and the current input byte
	always_ff @(posedge clk) begin
		if (head_we) begin
			head_q[head_widx] <= in_data;
		end
		if (in_take) begin
			byte_q <= in_data;
		end
	end

	// Select the byte of this step
	always_comb begin
		unique case (ctrl.cw.src)
			stfp_pkg::SRC_CONST: value = ctrl.cw.konst;
			stfp_pkg::SRC_HEAD:  value = head_q[ctrl.cw.head_idx];
			stfp_pkg::SRC_BYTE:  value = byte_q;
			stfp_pkg::SRC_PART:  value = {7'd0, part};
			stfp_pkg::SRC_CRC:   value = crc_q;
			default:             value = 8'h00;
		endcase
	end

	// Clear or advance the running CRC
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= 8'h00;
		end else if (ctrl.fire) begin
			if (ctrl.cw.crc_clr) begin
				crc_q <= 8'h00;
			end else if (ctrl.cw.crc_upd) begin
				crc_q <= stfp_pkg::crc8_step(crc_q, value);
			end
		end
	end

	assign slot_free = !out_valid_q || out_ready;

	// Hold the result until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.fire) begin
			out_byte_q   <= value;
			frame_part_q <= part;
			frame_end_q  <= ctrl.cw.frame_end;
			run_last_q   <= ctrl.last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign frame_part = frame_part_q;
	assign frame_end  = frame_end_q;
	assign run_last   = run_last_q;

endmodule

`default_nettype wire

>>> hdl/snapshot_two_frame_packer_crc8_unit.sv
// Snapshot two-frame packer with CRC-8.
// Input channel in_valid/in_ready carries one snapshot byte (snap_byte) per transaction;
// the byte position 0..65 is counted internally and wraps to 0 after 65.
// Output channel out_valid/out_ready carries one frame byte per transaction with
// frame_part, frame_end (the CRC byte) and run_last (last byte caused by one input).
// Bytes 0..8 are only buffered and produce nothing. Byte 9 starts frame 0 with a run of
// 25 bytes, byte 33 starts frame 1 with a run of 16 bytes, every other byte passes
// through as one byte, and bytes 32 and 65 are each followed by their frame's CRC byte.
// Timing: a microcode sequencer emits one output byte per cycle into the output register
// while the receiver does not stall. An input transaction that starts a run registers
// the start address and busy flag, and the steps then write the output register; the
// next input is taken the cycle after the last step. Nine buffer-only bytes leave the
// sequencer idle. The output register decouples the sides:
// the next input is accepted while the final result of a run is still waiting.
// A stalled receiver holds the sequencer at its current step; nothing is dropped.
// Reset clears the position to 0, the CRC and all handshake state; the head buffer
// needs no reset since each entry is written before it is read.
// Depends on stfp_pkg, stfp_ucode_rom and stfp_datapath.
`default_nettype none

module snapshot_two_frame_packer_crc8_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] snap_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            frame_part,
	output logic            frame_end,
	output logic            run_last
);

	logic [stfp_pkg::POS_W-1:0]     pos_q;
	logic [stfp_pkg::UC_ADDR_W-1:0] pc_q;
	logic                           busy_q;
	logic                           part_q;
	logic                           end_q;
	logic                           take;
	logic                           slot_free;
	logic                           last;
	stfp_pkg::ctrl_word_t           cw;
	stfp_pkg::dp_ctrl_t             ctrl;

	assign in_ready = !busy_q;
	assign take     = in_valid && in_ready;

	stfp_ucode_rom u_rom (
		.addr (pc_q),
		.word (cw)
	);

	// Decide whether this step ends the run
	always_comb begin
		unique case (cw.seq)
			stfp_pkg::SEQ_LAST:            last = 1'b1;
			stfp_pkg::SEQ_LAST_UNLESS_END: last = !end_q;
			default:                       last = 1'b0;
		endcase
	end

	assign ctrl.fire = busy_q && slot_free;
	assign ctrl.last = last;
	assign ctrl.cw   = cw;

	// Advance position, start runs and step the program counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			pc_q   <= stfp_pkg::UC_HEAD;
			busy_q <= 1'b0;
			part_q <= 1'b0;
			end_q  <= 1'b0;
		end else if (take) begin
			pos_q <= (pos_q == stfp_pkg::POS_LAST) ? '0 : pos_q + 1'b1;
			if (pos_q >= stfp_pkg::POS_FRAME0) begin
				busy_q <= 1'b1;
				part_q <= (pos_q >= stfp_pkg::POS_FRAME1);
				end_q  <= (pos_q == stfp_pkg::POS_END0) || (pos_q == stfp_pkg::POS_LAST);
				pc_q   <= ((pos_q == stfp_pkg::POS_FRAME0) || (pos_q == stfp_pkg::POS_FRAME1))
					? stfp_pkg::UC_HEAD : stfp_pkg::UC_PASS;
			end
		end else if (ctrl.fire) begin
			if (last) begin
				busy_q <= 1'b0;
			end else if (cw.seq == stfp_pkg::SEQ_JUMP_IF_PART1 && part_q) begin
				pc_q <= cw.target;
			end else begin
				pc_q <= pc_q + 1'b1;
			end
		end
	end

	stfp_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_take    (take),
		.head_we    (take && (pos_q < stfp_pkg::POS_W'(stfp_pkg::HEAD_LEN))),
		.head_widx  (pos_q[stfp_pkg::HEAD_W-1:0]),
		.in_data    (snap_byte),
		.part       (part_q),
		.ctrl       (ctrl),
		.slot_free  (slot_free),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.frame_part (frame_part),
		.frame_end  (frame_end),
		.run_last   (run_last)
	);

	// Position stays inside the snapshot
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < stfp_pkg::POS_W'(stfp_pkg::SNAP_LEN))
		else $error("byte position out of range");

	// Program counter stays inside the program while running
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (pc_q < stfp_pkg::UC_LEN))
		else $error("microcode address out of range");

	// Frame start launches the header program
	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		(take && (pos_q == stfp_pkg::POS_FRAME0 || pos_q == stfp_pkg::POS_FRAME1))
		|=> (busy_q && pc_q == stfp_pkg::UC_HEAD))
		else $error("frame start did not launch header");

	// Last step of a run releases the input side
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.fire && last) |=> !busy_q)
		else $error("sequencer stayed busy after last step");

	// CRC byte only at the end of a frame
	a_crc_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.fire && cw.frame_end) |-> (end_q && last))
		else $error("CRC byte outside frame end");

endmodule

`default_nettype wire
